// ===== src/stee_pkg.sv =====
// shared types and codes for the spanning tree edge exchange block
`default_nettype none
package stee_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam int TABU_PORTS = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEGREE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY    = 1'd1;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TRY  = 2'd1;
    localparam logic [1:0] OP_KEEP = 2'd2;
    // unused opcode, answered like a load that writes nothing
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NO_REMOVE = 2'd1;
    localparam logic [1:0] ST_IN_TREE   = 2'd2;

    localparam logic [4:0] DEG_MAX = 5'd31;

    typedef struct packed {
        logic [4:0] a;
        logic [4:0] b;
        logic [9:0] w;
        logic       mark;
    } t_edge_rec;

endpackage
`default_nettype wire

// ===== src/stee_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module stee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/spanning_tree_edge_exchange.sv =====
// top level: edge table, degree store and exchange sequencer
//
// channel  direction  handshake          payload
// input    in         i_valid / o_stall  opcode, edge, endpoints, cost, tabu list
// output   out        o_valid / i_stall  removed_edge, cost_change, violations, status
// config   in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// one transaction at a time; a load ends with a count of the violations
// an exchange runs pruning passes with an edge table scan per pruned leaf, walks the
// node pairs with a table scan per cycle node pair, makes the two violation counts
// and does setup and write-back; every scan goes through the edge ram's single read port
// edge entries are tracked by valid bits cleared at reset, so no clearing pass is needed
// a finished result waits in the output register while the next transaction is accepted
`default_nettype none
module spanning_tree_edge_exchange #(
    parameter int NODES    = 16,
    parameter int EDGES    = 120,
    parameter int TABU_LEN = 3
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [stee_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [stee_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [1:0]                       i_opcode,
    input  wire logic [6:0]                       i_edge_id,
    input  wire logic [4:0]                       i_node_a,
    input  wire logic [4:0]                       i_node_b,
    input  wire logic [9:0]                       i_edge_cost,
    input  wire logic                             i_edge_in_tree,
    input  wire logic                             i_tabu_mode,
    input  wire logic [6:0]                       i_tabu_id_0,
    input  wire logic [6:0]                       i_tabu_id_1,
    input  wire logic [6:0]                       i_tabu_id_2,
    input  wire logic [1:0]                       i_tabu_count,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [6:0]                            o_removed_edge,
    output logic signed [15:0]                    o_cost_change,
    output logic [4:0]                            o_violations,
    output logic [1:0]                            o_status
);
    import stee_pkg::*;

    localparam int EW  = $clog2(EDGES);
    localparam int EC  = $clog2(EDGES + 1);
    localparam int NIW = $clog2(NODES);
    localparam int NCW = $clog2(NODES + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_LD_RD, S_LD_WR, S_UPD_A, S_UPD_B, S_CNT, S_XCHK,
        S_PR_INIT, S_PR_NODE, S_PR_SCAN, S_PR_NEXT,
        S_PK_INIT, S_PK_LO, S_PK_HI, S_PK_SCAN, S_PK_DONE,
        S_MUL, S_SUM, S_WR_E, S_WR_R, S_FIN
    } t_state;

    typedef enum logic [1:0] {CK_LOAD, CK_BEFORE, CK_AFTER} t_cnt_kind;

    t_state    r_state, r_ret;
    t_cnt_kind r_kind;

    logic [1:0]  r_op;
    logic        r_id_ok;
    logic [EW-1:0] r_e;
    logic [4:0]  r_na, r_nb;
    logic [9:0]  r_cost;
    logic        r_intree;
    logic        r_mode;
    logic [6:0]  r_tabu [TABU_PORTS];
    logic [1:0]  r_tc;

    logic [3:0]  r_maxdeg;
    logic [9:0]  r_pen;

    logic [4:0]  r_deg  [NODES];
    logic [4:0]  r_pdeg [NODES];
    logic [4:0]  r_sdeg [NODES];
    logic [EDGES-1:0] r_evalid;

    logic [4:0]  r_ua, r_ub;
    logic        r_up;
    logic [NCW-1:0] r_ni, r_acc, r_lo, r_hi;
    logic        r_again;
    logic [EC-1:0] r_ej;
    logic [EW-1:0] r_rj;
    logic        r_rv;

    logic [4:0]  r_ea, r_eb, r_ra, r_rb;
    logic [9:0]  r_ew, r_rw, r_top;
    logic [6:0]  r_best;
    logic [4:0]  r_before, r_after;
    logic signed [17:0] r_prod;

    logic [6:0]  r_res_rem;
    logic signed [15:0] r_res_cost;
    logic [4:0]  r_res_viol;
    logic [1:0]  r_res_st;

    // edge ram
    logic          w_we;
    logic [EW-1:0] w_waddr, w_raddr;
    t_edge_rec     w_wdata, w_q;

    stee_ram #(.WIDTH($bits(t_edge_rec)), .DEPTH(EDGES)) u_edges (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    function automatic logic node_ok(input logic [4:0] n);
        return (n != 5'd0) && (32'(n) <= NODES);
    endfunction

    function automatic logic [NIW-1:0] node_idx(input logic [4:0] n);
        return NIW'(n - 5'd1);
    endfunction

    function automatic logic [4:0] deg_step(input logic [4:0] d, input logic up);
        if (up) begin
            return (d < DEG_MAX) ? d + 5'd1 : d;
        end
        return (d != 5'd0) ? d - 5'd1 : d;
    endfunction

    logic w_accept;
    logic w_id_ok_in;
    logic w_out_free;
    logic w_scan;
    logic w_issue;
    logic w_last;
    logic w_mark;
    logic w_hit;
    logic w_pair;
    logic [NCW-1:0] w_acc;
    logic [4:0] w_viol;
    logic [4:0] w_node, w_lo5, w_hi5;
    logic w_nb_b, w_nb_a;
    logic w_listed;
    logic [1:0] w_tc_eff;
    logic signed [10:0] w_pen_s;
    logic signed [6:0]  w_diff;
    logic signed [17:0] w_prod;
    logic signed [19:0] w_sum;
    logic signed [15:0] w_sat;

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_id_ok_in = (i_edge_id != 7'd0) && (32'(i_edge_id) <= EDGES);
    assign w_out_free = !o_valid || !i_stall;

    assign w_scan  = (r_state == S_PR_SCAN) || (r_state == S_PK_SCAN);
    assign w_issue = w_scan && (32'(r_ej) < EDGES);
    assign w_last  = r_rv && (32'(r_rj) == EDGES - 1);
    assign w_mark  = (r_evalid[r_rj] & w_q.mark) | (r_rj == r_e);

    assign w_hit  = (r_deg[r_ni[NIW-1:0]] > {1'b0, r_maxdeg});
    assign w_acc  = r_acc + NCW'(w_hit);
    assign w_viol = (32'(w_acc) > 31) ? 5'd31 : 5'(w_acc);

    assign w_node = 5'(r_ni) + 5'd1;
    assign w_lo5  = 5'(r_lo) + 5'd1;
    assign w_hi5  = 5'(r_hi) + 5'd1;
    assign w_nb_b = (w_q.a == w_node) && node_ok(w_q.b) && (r_pdeg[node_idx(w_q.b)] != 5'd0);
    assign w_nb_a = (w_q.b == w_node) && node_ok(w_q.a) && (r_pdeg[node_idx(w_q.a)] != 5'd0);
    // never-written entries are excluded by their valid bit and match no pair
    assign w_pair = r_rv && r_evalid[r_rj] && (w_q.a == w_lo5) && (w_q.b == w_hi5);

    assign w_tc_eff = (32'(r_tc) > TABU_LEN) ? 2'(TABU_LEN) : r_tc;
    always_comb begin
        w_listed = 1'b0;
        for (int k = 0; k < TABU_PORTS; k++) begin
            if ((k < 32'(w_tc_eff)) && (32'(r_tabu[k]) == 32'(r_rj) + 1)) begin
                w_listed = 1'b1;
            end
        end
    end

    assign w_pen_s = $signed({1'b0, r_pen});
    assign w_diff  = $signed({2'b0, r_after}) - $signed({2'b0, r_before});
    assign w_prod  = w_pen_s * w_diff;
    assign w_sum   = $signed({10'd0, r_ew}) - $signed({10'd0, r_rw})
                   + $signed({{2{r_prod[17]}}, r_prod});
    assign w_sat   = (w_sum > 20'sd32767) ? 16'sd32767 :
                     (w_sum < -20'sd32768) ? -16'sd32768 : 16'(w_sum);

    always_comb begin
        w_raddr = r_ej[EW-1:0];
        if (r_state == S_IDLE) begin
            w_raddr = EW'(i_edge_id - 7'd1);
        end else if (r_state == S_CNT) begin
            w_raddr = r_e;
        end
        w_we    = 1'b0;
        w_waddr = r_e;
        w_wdata = '{a: r_na, b: r_nb, w: r_cost, mark: r_intree};
        unique case (r_state)
            S_LD_WR: w_we = 1'b1;
            S_WR_E: begin
                w_we    = 1'b1;
                w_wdata = '{a: r_ea, b: r_eb, w: r_ew, mark: 1'b1};
            end
            S_WR_R: begin
                w_we    = 1'b1;
                w_waddr = EW'(r_best - 7'd1);
                w_wdata = '{a: r_ra, b: r_rb, w: r_rw, mark: 1'b0};
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_kind   <= CK_LOAD;
            r_maxdeg <= 4'd3;
            r_pen    <= 10'd100;
            r_evalid <= '0;
            r_rv     <= 1'b0;
            r_again  <= 1'b0;
            o_valid  <= 1'b0;
            for (int i = 0; i < NODES; i++) begin
                r_deg[i]  <= '0;
                r_pdeg[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_DEGREE: r_maxdeg <= i_cfg_data[3:0];
                    CFG_PENALTY:    r_pen    <= i_cfg_data;
                endcase
            end
            if (o_valid && !i_stall && (r_state != S_FIN)) begin
                o_valid <= 1'b0;
            end
            if (w_issue) begin
                r_rj <= r_ej[EW-1:0];
                r_ej <= r_ej + EC'(1);
            end
            if (w_scan) begin
                r_rv <= w_issue;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op     <= i_opcode;
                        r_id_ok  <= w_id_ok_in;
                        r_e      <= EW'(i_edge_id - 7'd1);
                        r_na     <= i_node_a;
                        r_nb     <= i_node_b;
                        r_cost   <= i_edge_cost;
                        r_intree <= i_edge_in_tree;
                        r_mode   <= i_tabu_mode;
                        r_tabu[0] <= i_tabu_id_0;
                        r_tabu[1] <= i_tabu_id_1;
                        r_tabu[2] <= i_tabu_id_2;
                        r_tc     <= i_tabu_count;
                        r_ni     <= '0;
                        r_acc    <= '0;
                        if (i_opcode == OP_LOAD && w_id_ok_in) begin
                            r_state <= S_LD_RD;
                        end else if (i_opcode == OP_TRY || i_opcode == OP_KEEP) begin
                            r_kind  <= CK_BEFORE;
                            r_state <= S_CNT;
                        end else begin
                            r_kind  <= CK_LOAD;
                            r_state <= S_CNT;
                        end
                    end
                end
                S_LD_RD: begin
                    // withdraw the old tree edge before overwriting it
                    if (r_evalid[r_e] && w_q.mark) begin
                        r_ua    <= w_q.a;
                        r_ub    <= w_q.b;
                        r_up    <= 1'b0;
                        r_ret   <= S_LD_WR;
                        r_state <= S_UPD_A;
                    end else begin
                        r_state <= S_LD_WR;
                    end
                end
                S_LD_WR: begin
                    r_evalid[r_e] <= 1'b1;
                    r_kind <= CK_LOAD;
                    r_ni   <= '0;
                    r_acc  <= '0;
                    if (r_intree) begin
                        r_ua    <= r_na;
                        r_ub    <= r_nb;
                        r_up    <= 1'b1;
                        r_ret   <= S_CNT;
                        r_state <= S_UPD_A;
                    end else begin
                        r_state <= S_CNT;
                    end
                end
                S_UPD_A: begin
                    if (node_ok(r_ua)) begin
                        r_deg[node_idx(r_ua)] <= deg_step(r_deg[node_idx(r_ua)], r_up);
                    end
                    r_state <= S_UPD_B;
                end
                S_UPD_B: begin
                    if (node_ok(r_ub)) begin
                        r_deg[node_idx(r_ub)] <= deg_step(r_deg[node_idx(r_ub)], r_up);
                    end
                    r_ni    <= '0;
                    r_acc   <= '0;
                    r_state <= r_ret;
                end
                S_CNT: begin
                    r_acc <= w_acc;
                    r_ni  <= r_ni + NCW'(1);
                    if (32'(r_ni) == NODES - 1) begin
                        unique case (r_kind)
                            CK_LOAD: begin
                                r_res_rem  <= '0;
                                r_res_cost <= '0;
                                r_res_viol <= w_viol;
                                r_res_st   <= ST_DONE;
                                r_state    <= S_FIN;
                            end
                            CK_BEFORE: begin
                                r_before   <= w_viol;
                                r_res_rem  <= '0;
                                r_res_cost <= '0;
                                r_res_viol <= w_viol;
                                r_res_st   <= ST_NO_REMOVE;
                                r_state    <= r_id_ok ? S_XCHK : S_FIN;
                            end
                            default: begin
                                r_after <= w_viol;
                                r_state <= S_MUL;
                            end
                        endcase
                    end
                end
                S_XCHK: begin
                    if (r_evalid[r_e] && w_q.mark) begin
                        r_res_st <= ST_IN_TREE;
                        r_state  <= S_FIN;
                    end else begin
                        r_ea <= w_q.a;
                        r_eb <= w_q.b;
                        r_ew <= w_q.w;
                        for (int i = 0; i < NODES; i++) begin
                            r_sdeg[i] <= r_deg[i];
                        end
                        r_ua    <= w_q.a;
                        r_ub    <= w_q.b;
                        r_up    <= 1'b1;
                        r_ret   <= S_PR_INIT;
                        r_state <= S_UPD_A;
                    end
                end
                S_PR_INIT: begin
                    for (int i = 0; i < NODES; i++) begin
                        r_pdeg[i] <= r_deg[i];
                    end
                    r_ni    <= '0;
                    r_again <= 1'b0;
                    r_state <= S_PR_NODE;
                end
                S_PR_NODE: begin
                    if (r_pdeg[r_ni[NIW-1:0]] == 5'd1) begin
                        r_pdeg[r_ni[NIW-1:0]] <= '0;
                        r_again <= 1'b1;
                        r_ej    <= '0;
                        r_rv    <= 1'b0;
                        r_state <= S_PR_SCAN;
                    end else begin
                        r_state <= S_PR_NEXT;
                    end
                end
                S_PR_SCAN: begin
                    // first tree edge that reaches a live neighbour
                    if (r_rv && w_mark && (w_nb_b || w_nb_a)) begin
                        if (w_nb_b) begin
                            r_pdeg[node_idx(w_q.b)] <= r_pdeg[node_idx(w_q.b)] - 5'd1;
                        end else begin
                            r_pdeg[node_idx(w_q.a)] <= r_pdeg[node_idx(w_q.a)] - 5'd1;
                        end
                        r_state <= S_PR_NEXT;
                    end else if (w_last) begin
                        r_state <= S_PR_NEXT;
                    end
                end
                S_PR_NEXT: begin
                    if (32'(r_ni) == NODES - 1) begin
                        r_ni <= '0;
                        if (r_again) begin
                            r_again <= 1'b0;
                            r_state <= S_PR_NODE;
                        end else begin
                            r_state <= S_PK_INIT;
                        end
                    end else begin
                        r_ni    <= r_ni + NCW'(1);
                        r_state <= S_PR_NODE;
                    end
                end
                S_PK_INIT: begin
                    r_lo    <= '0;
                    r_best  <= '0;
                    r_top   <= '0;
                    r_state <= S_PK_LO;
                end
                S_PK_LO: begin
                    if (32'(r_lo) == NODES) begin
                        r_state <= S_PK_DONE;
                    end else if (r_pdeg[r_lo[NIW-1:0]] != 5'd0) begin
                        r_hi    <= r_lo + NCW'(1);
                        r_state <= S_PK_HI;
                    end else begin
                        r_lo <= r_lo + NCW'(1);
                    end
                end
                S_PK_HI: begin
                    if (32'(r_hi) == NODES) begin
                        r_lo    <= r_lo + NCW'(1);
                        r_state <= S_PK_LO;
                    end else if (r_pdeg[r_hi[NIW-1:0]] != 5'd0) begin
                        r_ej    <= '0;
                        r_rv    <= 1'b0;
                        r_state <= S_PK_SCAN;
                    end else begin
                        r_hi <= r_hi + NCW'(1);
                    end
                end
                S_PK_SCAN: begin
                    // first edge stored as this node pair decides for the pair
                    if (w_pair) begin
                        if (w_mark && w_q.w > r_top && w_listed == r_mode) begin
                            r_top  <= w_q.w;
                            r_best <= 7'(r_rj) + 7'd1;
                            r_ra   <= w_q.a;
                            r_rb   <= w_q.b;
                            r_rw   <= w_q.w;
                        end
                        r_hi    <= r_hi + NCW'(1);
                        r_state <= S_PK_HI;
                    end else if (w_last) begin
                        r_hi    <= r_hi + NCW'(1);
                        r_state <= S_PK_HI;
                    end
                end
                S_PK_DONE: begin
                    if (r_best == 7'd0) begin
                        for (int i = 0; i < NODES; i++) begin
                            r_deg[i] <= r_sdeg[i];
                        end
                        r_res_st <= ST_NO_REMOVE;
                        r_state  <= S_FIN;
                    end else begin
                        r_ua    <= r_ra;
                        r_ub    <= r_rb;
                        r_up    <= 1'b0;
                        r_kind  <= CK_AFTER;
                        r_ret   <= S_CNT;
                        r_state <= S_UPD_A;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_res_rem  <= r_best;
                    r_res_cost <= w_sat;
                    r_res_viol <= r_after;
                    r_res_st   <= ST_DONE;
                    if (r_op == OP_KEEP) begin
                        r_state <= S_WR_E;
                    end else begin
                        for (int i = 0; i < NODES; i++) begin
                            r_deg[i] <= r_sdeg[i];
                        end
                        r_state <= S_FIN;
                    end
                end
                S_WR_E: begin
                    r_evalid[r_e] <= 1'b1;
                    r_state <= S_WR_R;
                end
                S_WR_R: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        o_valid        <= 1'b1;
                        o_removed_edge <= r_res_rem;
                        o_cost_change  <= r_res_cost;
                        o_violations   <= r_res_viol;
                        o_status       <= r_res_st;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a result without a completed exchange carries no removal and no cost
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_DONE) |-> (o_removed_edge == 7'd0 && o_cost_change == 16'sd0))
        else $error("failed exchange reports a removal or cost");

    // an accepted transaction always starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted transaction left the sequencer idle");

    // a new result only appears once the previous one was taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("pending result dropped");

    // the edge chosen for removal lies on the cycle found by pruning
    a_pick_on_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PK_SCAN && w_pair)
            |-> (r_pdeg[r_lo[NIW-1:0]] != 5'd0 && r_pdeg[r_hi[NIW-1:0]] != 5'd0))
        else $error("candidate pair not on the cycle");
endmodule
`default_nettype wire
